FILE: sv/box_blur_3x3_rgb_macros.svh
// Assertion macros shared by the box blur RTL.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define BB3_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition must never be seen on a clock edge outside reset.
`define BB3_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

FILE: sv/bb3_pkg.sv
// Types, constants and the reciprocal table of the 3x3 RGB box blur.
package bb3_pkg;

   localparam int CFG_W          = 11;
   localparam int COL_W          = 11;
   localparam int ROW_W          = 12;
   localparam int CH_W           = 8;
   localparam int NUM_LANES      = 3;
   localparam int PIX_W          = CH_W * NUM_LANES;
   localparam int TAPS           = 9;
   localparam int CNT_W          = 4;
   localparam int ROWSUM_W       = 10;
   localparam int NUM_W          = 13;
   localparam int RECIP_W        = 16;
   localparam int PROD_W         = NUM_W + RECIP_W;
   localparam int Q_W            = 9;
   localparam int CSR_IDX_W      = 2;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_MUL,
      ST_FIX
   } bb3_state_type;

   typedef struct packed {
      logic             load_rows;
      logic             load_num;
      logic             load_q;
      logic [2:0]       row_en;
      logic [2:0]       col_en;
      logic [CNT_W-1:0] count;
   } bb3_lane_ctl_type;

   typedef struct packed {
      logic row_end;
      logic frame_end;
   } bb3_flags_type;

   // floor(2^16 / (2*n)) for a window of n pixels
   function automatic logic [RECIP_W-1:0] bb3_recip(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd1:    r = 16'd32768;
         4'd2:    r = 16'd16384;
         4'd3:    r = 16'd10922;
         4'd4:    r = 16'd8192;
         4'd5:    r = 16'd6553;
         4'd6:    r = 16'd5461;
         4'd7:    r = 16'd4681;
         4'd8:    r = 16'd4096;
         4'd9:    r = 16'd3640;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/bb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bb3_lane.sv
// One colour lane: clipped window sum and rounded mean by reciprocal multiply.
module bb3_lane import bb3_pkg::*; (
   input  logic                        clock,
   input  bb3_lane_ctl_type            ctl,
   input  logic [TAPS-1:0][CH_W-1:0]   taps,
   output logic [CH_W-1:0]             mean
);

   logic [2:0][ROWSUM_W-1:0] rsum;
   logic [2:0][ROWSUM_W-1:0] rsum_ff;
   logic [NUM_W-1:0]         total;
   logic [NUM_W-1:0]         num_ff;
   logic [PROD_W-1:0]        prod;
   logic [Q_W-1:0]           q0_ff;
   logic [NUM_W-1:0]         div;
   logic [NUM_W-1:0]         qd;
   logic [NUM_W-1:0]         rem;
   logic [Q_W-1:0]           q_fix;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsum[i] = (ctl.col_en[0] ? ROWSUM_W'(taps[i*3])     : '0)
                 + (ctl.col_en[1] ? ROWSUM_W'(taps[i*3 + 1]) : '0)
                 + (ctl.col_en[2] ? ROWSUM_W'(taps[i*3 + 2]) : '0);
      end
   end

   assign total = NUM_W'(rsum_ff[0]) + NUM_W'(rsum_ff[1]) + NUM_W'(rsum_ff[2]);
   assign prod  = PROD_W'(num_ff) * PROD_W'(bb3_recip(ctl.count));

   always_ff @(posedge clock) begin
      if (ctl.load_rows) begin
         for (int i = 0; i < 3; i++) begin
            rsum_ff[i] <= ctl.row_en[i] ? rsum[i] : '0;
         end
      end
      if (ctl.load_num) begin
         num_ff <= {total[NUM_W-2:0], 1'b0} + NUM_W'(ctl.count);
      end
      if (ctl.load_q) begin
         q0_ff <= prod[RECIP_W +: Q_W];
      end
   end

   // estimate is exact or one short
   assign div   = NUM_W'({ctl.count, 1'b0});
   assign qd    = NUM_W'(q0_ff) * div;
   assign rem   = num_ff - qd;
   assign q_fix = (rem >= div) ? q0_ff + 1'b1 : q0_ff;
   assign mean  = q_fix[CH_W-1:0];

endmodule

FILE: sv/bb3_merge.sv
// Output register: joins the three lane means and the position flags.
module bb3_merge import bb3_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            ld,
   input  logic [NUM_LANES-1:0][CH_W-1:0]  means,
   input  bb3_flags_type                   flags,
   output logic                            free,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [PIX_W-1:0]                rsp_tdata,   // red_out, green_out, blue_out
   output logic                            rsp_tlast,   // row_end
   output logic                            rsp_tuser    // frame_end
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [PIX_W-1:0]     data_ff;
   bb3_flags_type        flags_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = ld || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         data_ff  <= means;
         flags_ff <= flags;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = flags_ff.row_end;
   assign rsp_tuser  = flags_ff.frame_end;

endmodule

FILE: sv/box_blur_3x3_rgb.sv
// Top level of the 3x3 RGB box blur: position tracking, line stores, window and sequencer.
// Pixels enter in raster order; each output is the per-channel mean of the 3x3
// neighbourhood clipped to the image, rounded half up. Results lag the input by one
// row plus one pixel, so after a W x H frame send W+1 flush transactions (tuser = 1);
// the transaction after the last flush begins the next frame. A transaction that
// yields no result occupies the block for the line store read, then the window
// update; one that yields a result is walked by the sequencer through the line store
// read, the row sums, the total and the reciprocal multiply and correction that each
// of the three colour lanes performs on its own. A finished result waits in the
// output register while the next transaction is taken. Writing either size register
// restarts the frame at its first pixel. The line stores need no clearing after reset.
`include "box_blur_3x3_rgb_macros.svh"

module box_blur_3x3_rgb import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // red, green, blue
   input  logic                  req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // red_out, green_out, blue_out
   output logic                  rsp_tlast,   // row_end
   output logic                  rsp_tuser,   // frame_end
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   bb3_state_type           state_ff, state_in;
   logic [CFG_W-1:0]        width_ff, height_ff;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [ROW_W-1:0]        in_row_ff, in_row_in;

   logic [CFG_W-1:0]        w_eff, h_eff;
   logic [ROW_W-1:0]        h_ext;
   logic [COL_W-1:0]        c_eff;
   logic                    accept, csr_hit, edge_c, int_c;
   logic [ROW_W-1:0]        orow;
   logic [COL_W-1:0]        ocol;
   logic [2:0]              row_en, col_en;
   logic [1:0]              nr, nc;

   logic [PIX_W-1:0]        pix_ff;
   logic [AW-1:0]           ci_ff;
   logic                    emit_ff, edge_ff;
   logic [2:0]              row_en_ff, col_en_ff;
   logic [CNT_W-1:0]        count_ff;
   bb3_flags_type           flags_ff;

   logic [PIX_W-1:0]        up_rd, mid_rd;
   logic                    ram_we;
   logic [TAPS-1:0][PIX_W-1:0] win_ff, win_in, win_use;
   logic [2:0][PIX_W-1:0]   col_new;

   bb3_lane_ctl_type        lane_ctl;
   logic [NUM_LANES-1:0][CH_W-1:0] means;
   logic                    mrg_ld, mrg_free;

   // size registers and frame position
   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready &&
                      (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = CFG_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = CFG_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign h_ext = ROW_W'(h_eff);
   assign c_eff = (in_col_ff >= w_eff) ? '0 : in_col_ff;

   always_comb begin
      edge_c = (c_eff == '0) && (in_row_ff >= ROW_W'(2)) && (in_row_ff <= h_ext + 1'b1);
      int_c  = (c_eff != '0) && (in_row_ff >= ROW_W'(1)) && (in_row_ff <= h_ext);
      orow   = edge_c ? in_row_ff - ROW_W'(2) : in_row_ff - ROW_W'(1);
      ocol   = edge_c ? w_eff - 1'b1 : c_eff - 1'b1;
      row_en = {(orow + 1'b1) < h_ext, 1'b1, orow >= ROW_W'(1)};
      col_en = edge_c ? {1'b1, w_eff >= CFG_W'(2), 1'b0} : {2'b11, ocol >= COL_W'(1)};
      nr     = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
      nc     = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);
      if (in_row_ff >= h_ext + 1'b1) begin
         in_row_in = '0;
         in_col_in = '0;
      end else if (c_eff == w_eff - 1'b1) begin
         in_row_in = in_row_ff + 1'b1;
         in_col_in = '0;
      end else begin
         in_row_in = in_row_ff;
         in_col_in = c_eff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(DEF_MAX_WIDTH);
         height_ff <= CFG_W'(DEF_MAX_HEIGHT);
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (csr_hit) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_ff <= csr_data;
         end else begin
            height_ff <= csr_data;
         end
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (accept) begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff    <= req_tuser ? '0 : req_tdata;
         ci_ff     <= AW'(c_eff);
         emit_ff   <= edge_c || int_c;
         edge_ff   <= edge_c;
         row_en_ff <= row_en;
         col_en_ff <= col_en;
         count_ff  <= CNT_W'(nr) * CNT_W'(nc);
         flags_ff.row_end   <= (ocol == w_eff - 1'b1);
         flags_ff.frame_end <= (ocol == w_eff - 1'b1) && (orow == h_ext - 1'b1);
      end
   end

   // line stores: two rows above the current one
   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .ADDR_W(AW)) u_upper (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ci_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (AW'(c_eff)),
      .rd_data (up_rd)
   );

   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .ADDR_W(AW)) u_middle (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ci_ff),
      .wr_data (pix_ff),
      .rd_en   (accept),
      .rd_addr (AW'(c_eff)),
      .rd_data (mid_rd)
   );

   // window: rows top to bottom, columns oldest to newest
   assign col_new = {pix_ff, mid_rd, up_rd};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3]     = win_ff[i*3 + 1];
         win_in[i*3 + 1] = win_ff[i*3 + 2];
         win_in[i*3 + 2] = col_new[i];
      end
   end

   // end-of-row result is centred on the window before the shift
   assign win_use = edge_ff ? win_ff : win_in;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         win_ff <= win_in;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = emit_ff ? ST_SUM : ST_IDLE;
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIX;
         ST_FIX: begin
            if (mrg_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready         = 1'b0;
      ram_we             = 1'b0;
      mrg_ld             = 1'b0;
      lane_ctl.load_rows = 1'b0;
      lane_ctl.load_num  = 1'b0;
      lane_ctl.load_q    = 1'b0;
      lane_ctl.row_en    = row_en_ff;
      lane_ctl.col_en    = col_en_ff;
      lane_ctl.count     = count_ff;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_READ: begin
            ram_we             = 1'b1;
            lane_ctl.load_rows = emit_ff;
         end
         ST_SUM:  lane_ctl.load_num = 1'b1;
         ST_MUL:  lane_ctl.load_q   = 1'b1;
         ST_FIX:  mrg_ld = mrg_free;
         default: req_tready = 1'b0;
      endcase
   end

   // colour lanes
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      logic [TAPS-1:0][CH_W-1:0] taps;

      always_comb begin
         for (int t = 0; t < TAPS; t++) begin
            taps[t] = win_use[t][k*CH_W +: CH_W];
         end
      end

      bb3_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .taps  (taps),
         .mean  (means[k])
      );
   end

   bb3_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ld         (mrg_ld),
      .means      (means),
      .flags      (flags_ff),
      .free       (mrg_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `BB3_ASSERT(a_accept_reads, accept |=> state_ff == ST_READ, "transaction did not start a line store read")
   `BB3_ASSERT_NEVER(a_no_overwrite, mrg_ld && rsp_tvalid && !rsp_tready, "result overwritten before taken")
   `BB3_ASSERT(a_count_range, state_ff == ST_SUM |-> (count_ff >= 4'd1) && (count_ff <= 4'd9), "window count out of range")
   `BB3_ASSERT(a_quiet_return, (state_ff == ST_READ) && !emit_ff |=> state_ff == ST_IDLE, "resultless transaction held the block")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the 3x3 RGB box blur: directed frames, then random frames.
`timescale 1ns / 1ps

module testbench import bb3_pkg::*; ();

   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_ITEMS  = 620;

   localparam bit MODE_PIXEL = 1'b0;
   localparam bit MODE_FLUSH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            row_end;
      logic            frame_end;
   } blur_result_type;

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     val;
      bit                   flush;
      logic [CH_W-1:0]      red;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      blue;
      bit                   typed;
      blur_result_type      want;
   } stim_row_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata  = '0;   // red, green, blue
   logic                 req_tuser  = 1'b0; // mode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIX_W-1:0]     rsp_tdata;         // red_out, green_out, blue_out
   logic                 rsp_tlast;         // row_end
   logic                 rsp_tuser;         // frame_end
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_data   = '0;

   box_blur_3x3_rgb DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // blur predictor state
   logic [CFG_W-1:0] cfg_width  = CFG_W'(DEF_MAX_WIDTH);
   logic [CFG_W-1:0] cfg_height = CFG_W'(DEF_MAX_HEIGHT);
   pixel_type        upper_line  [DEF_MAX_WIDTH];
   pixel_type        middle_line [DEF_MAX_WIDTH];
   pixel_type        win [3][3];
   int               pos_row = 0;
   int               pos_col = 0;

   blur_result_type  blur_expected [$];
   stim_row_type     directed_rows [$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int cycles          = 0;
   int mismatches      = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int frames_run      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, blur_expected.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   function automatic int clamp_size(input logic [CFG_W-1:0] v, input int max_size);
      if (v < 1) return 1;
      if (v > max_size) return max_size;
      return int'(v);
   endfunction

   function automatic logic [CH_W-1:0] rounded_mean(input int sum, input int cnt);
      return CH_W'((2 * sum + cnt) / (2 * cnt));
   endfunction

   function automatic blur_result_type window_mean(input int r0, input int r1, input int c0,
                                                   input int c1, input int orow, input int ocol,
                                                   input int w, input int h);
      blur_result_type res;
      int sr, sg, sb, cnt;
      sr = 0; sg = 0; sb = 0; cnt = 0;
      for (int i = r0; i <= r1; i++)
         for (int j = c0; j <= c1; j++) begin
            sr += win[i][j].red;
            sg += win[i][j].green;
            sb += win[i][j].blue;
            cnt++;
         end
      res.red       = rounded_mean(sr, cnt);
      res.green     = rounded_mean(sg, cnt);
      res.blue      = rounded_mean(sb, cnt);
      res.row_end   = (ocol == w - 1);
      res.frame_end = (ocol == w - 1) && (orow == h - 1);
      return res;
   endfunction

   task automatic blur_step(input bit flush, input logic [CH_W-1:0] rd, gr, bl,
                            output bit got, output blur_result_type res);
      int w, h, r, c, orow;
      pixel_type px, up, mid;
      w = clamp_size(cfg_width, DEF_MAX_WIDTH);
      h = clamp_size(cfg_height, DEF_MAX_HEIGHT);
      r = pos_row;
      c = pos_col;
      got = 1'b0;
      res = '0;
      if (c >= w) c = 0;
      px = (flush == MODE_FLUSH) ? pixel_type'('0) : pixel_type'{rd, gr, bl};
      // end of an earlier row: centre sits in the right window column
      if (c == 0 && r >= 2 && r <= h + 1) begin
         orow = r - 2;
         res = window_mean(orow >= 1 ? 0 : 1, (orow + 1 < h) ? 2 : 1, w >= 2 ? 1 : 2, 2,
                           orow, w - 1, w, h);
         got = 1'b1;
      end
      up  = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = px;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      if (c >= 1 && r >= 1 && r <= h) begin
         orow = r - 1;
         res = window_mean(orow >= 1 ? 0 : 1, (orow + 1 < h) ? 2 : 1, (c - 1 >= 1) ? 0 : 1, 2,
                           orow, c - 1, w, h);
         got = 1'b1;
      end
      if (r >= h + 1) begin
         pos_row = 0;
         pos_col = 0;
      end else if (c + 1 >= w) begin
         pos_col = 0;
         pos_row = r + 1;
      end else begin
         pos_col = c + 1;
         pos_row = r;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 100)
         $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                  results_checked);
   endtask

   always @(negedge clock) begin
      blur_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (blur_expected.size() == 0) begin
            report_mismatch("result transaction with nothing pending", rsp_tdata, 0);
         end else begin
            want = blur_expected.pop_front();
            if (rsp_tdata[CH_W-1:0] !== want.red)
               report_mismatch("red_out", rsp_tdata[CH_W-1:0], want.red);
            if (rsp_tdata[2*CH_W-1:CH_W] !== want.green)
               report_mismatch("green_out", rsp_tdata[2*CH_W-1:CH_W], want.green);
            if (rsp_tdata[3*CH_W-1:2*CH_W] !== want.blue)
               report_mismatch("blue_out", rsp_tdata[3*CH_W-1:2*CH_W], want.blue);
            if (rsp_tlast !== want.row_end)
               report_mismatch("row_end", rsp_tlast, want.row_end);
            if (rsp_tuser !== want.frame_end)
               report_mismatch("frame_end", rsp_tuser, want.frame_end);
         end
      end
   end

   // drains the block; an item with no result may still be in flight
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (blur_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      bit taken;
      wait_quiet();
      if (idx == CSR_IMAGE_WIDTH || idx == CSR_IMAGE_HEIGHT) begin
         if (idx == CSR_IMAGE_WIDTH) cfg_width = val;
         else cfg_height = val;
         pos_row = 0;
         pos_col = 0;
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(input bit flush, input logic [CH_W-1:0] rd, gr, bl,
                            input bit typed, input blur_result_type want);
      int gap;
      bit got, taken;
      blur_result_type res;
      blur_step(flush, rd, gr, bl, got, res);
      if (typed) blur_expected.push_back(want);
      else if (got) blur_expected.push_back(res);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= flush;
      req_tdata  <= {bl, gr, rd};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   // one frame plus its flush tail, cut short after `cut` transactions
   task automatic run_frame(input int cut);
      int w, h, npix, total;
      bit flush;
      w = clamp_size(cfg_width, DEF_MAX_WIDTH);
      h = clamp_size(cfg_height, DEF_MAX_HEIGHT);
      npix = w * h;
      total = npix + w + 1;
      if (cut > total) cut = total;
      for (int i = 0; i < cut; i++) begin
         if (i < npix) flush = ($urandom_range(99) < 5);
         else flush = ($urandom_range(99) < 80);
         send_item(flush, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                   CH_W'($urandom_range(255)), 1'b0, '0);
      end
      frames_run++;
   endtask

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] val);
      stim_row_type s;
      s = '{default: '0};
      s.is_csr = 1'b1;
      s.idx    = idx;
      s.val    = val;
      return s;
   endfunction

   function automatic stim_row_type item_row(input bit flush,
                                             input logic [CH_W-1:0] rd, gr, bl);
      stim_row_type s;
      s = '{default: '0};
      s.flush = flush;
      s.red   = rd;
      s.green = gr;
      s.blue  = bl;
      return s;
   endfunction

   // last flush of a 1x1 frame: the lone pixel comes back, ending row and frame
   function automatic stim_row_type item_row_exp(input bit flush,
                                                 input logic [CH_W-1:0] rd, gr, bl,
                                                 input logic [CH_W-1:0] er, eg, eb);
      stim_row_type s;
      s = item_row(flush, rd, gr, bl);
      s.typed = 1'b1;
      s.want  = '{er, eg, eb, 1'b1, 1'b1};
      return s;
   endfunction

   initial begin
      int w, h, sel, cut, total, start_count, random_sent;
      bit need_cfg;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;

      directed_rows.push_back(csr_row(CSR_IMAGE_WIDTH, 11'd1));
      directed_rows.push_back(csr_row(CSR_IMAGE_HEIGHT, 11'd1));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd255, 8'd0, 8'd128));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
      directed_rows.push_back(item_row_exp(MODE_FLUSH, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd0, 8'd255, 8'd1));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd255, 8'd255, 8'd255));
      directed_rows.push_back(item_row_exp(MODE_FLUSH, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd1));
      // flush tick standing in for the pixel: black
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd255, 8'd255, 8'd255));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
      directed_rows.push_back(item_row_exp(MODE_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      // pixels in the flush tail are dropped
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd10, 8'd20, 8'd30));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd255, 8'd255, 8'd255));
      directed_rows.push_back(item_row_exp(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 8'd10, 8'd20, 8'd30));
      // zero sizes clamp to one
      directed_rows.push_back(csr_row(CSR_IMAGE_WIDTH, 11'd0));
      directed_rows.push_back(csr_row(CSR_IMAGE_HEIGHT, 11'd0));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd1, 8'd2, 8'd3));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
      directed_rows.push_back(item_row_exp(MODE_FLUSH, 8'd0, 8'd0, 8'd0, 8'd1, 8'd2, 8'd3));
      // unknown register indexes leave size and position alone
      directed_rows.push_back(csr_row(CSR_UNUSED_A, 11'd5));
      directed_rows.push_back(csr_row(CSR_UNUSED_B, 11'd2047));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd200, 8'd100, 8'd50));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
      directed_rows.push_back(item_row_exp(MODE_FLUSH, 8'd0, 8'd0, 8'd0, 8'd200, 8'd100, 8'd50));
      directed_rows.push_back(csr_row(CSR_IMAGE_WIDTH, 11'd2));
      directed_rows.push_back(csr_row(CSR_IMAGE_HEIGHT, 11'd2));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd255, 8'd255, 8'd255));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd0, 8'd0, 8'd0));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd255, 8'd0, 8'd1));
      directed_rows.push_back(item_row(MODE_PIXEL, 8'd3, 8'd254, 8'd128));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
      directed_rows.push_back(item_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0));

      send_idle_pct = 22;
      recv_idle_pct = 57;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            write_register(directed_rows[i].idx, directed_rows[i].val);
         else
            send_item(directed_rows[i].flush, directed_rows[i].red, directed_rows[i].green,
                      directed_rows[i].blue, directed_rows[i].typed, directed_rows[i].want);
      end

      random_sent = 0;
      need_cfg = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         if (need_cfg || $urandom_range(99) < 70) begin
            if ($urandom_range(99) < 10) begin
               w = $urandom_range(9, 40);
               h = $urandom_range(1, 3);
            end else begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 6);
            end
            sel = $urandom_range(99);
            if (sel < 15 || sel >= 30) write_register(CSR_IMAGE_WIDTH, CFG_W'(w));
            if (sel >= 15) write_register(CSR_IMAGE_HEIGHT, CFG_W'(h));
            if ($urandom_range(99) < 8)
               write_register($urandom_range(1) ? CSR_UNUSED_A : CSR_UNUSED_B,
                              CFG_W'($urandom_range(2047)));
            need_cfg = 1'b0;
         end
         w = clamp_size(cfg_width, DEF_MAX_WIDTH);
         h = clamp_size(cfg_height, DEF_MAX_HEIGHT);
         total = w * h + w + 1;
         cut = total;
         // broken frame: abandoned part way, then restarted by a size write
         if ($urandom_range(99) < 10) begin
            cut = $urandom_range(1, total - 1);
            need_cfg = 1'b1;
         end
         start_count = items_sent;
         run_frame(cut);
         random_sent += items_sent - start_count;
         if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 57;
            recv_idle_pct = 22;
         end
      end

      wait_quiet();
      $display("covered %0d frames: clipped edges and corners, flush ticks, clamped sizes,",
               frames_run);
      $display("restarts and ignored writes; %0d transactions in, %0d results compared",
               items_sent, results_checked);
      if (mismatches == 0 && blur_expected.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
